/* rtl/core/sha512_pkg.sv */
// Package: types, constants and round functions for the SHA-512/384 hash core.
package sha512_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic       init;
    logic [6:0] round;
  } rnd_ctl_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam int unsigned LenStart = 112;
  localparam int unsigned Rounds = 80;

  localparam logic [63:0] Iv512 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
  localparam logic [63:0] Iv384 [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};

  localparam logic [63:0] Rk [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] big_s0(input logic [63:0] a);
    big_s0 = rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39);
  endfunction

  function automatic logic [63:0] big_s1(input logic [63:0] e);
    big_s1 = rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41);
  endfunction

  function automatic logic [63:0] sm_s0(input logic [63:0] b);
    sm_s0 = rotr(b, 1) ^ rotr(b, 8) ^ (b >> 7);
  endfunction

  function automatic logic [63:0] sm_s1(input logic [63:0] a);
    sm_s1 = rotr(a, 19) ^ rotr(a, 61) ^ (a >> 6);
  endfunction

endpackage

/* rtl/core/sha512_round.sv */
// One shared SHA-512 round unit with a 16-word message schedule window.
module sha512_round (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha512_pkg::rnd_ctl_t  ctl_i,
  input  logic [63:0]           w_in_i,
  input  logic [63:0]           cv_i [8],
  output logic [63:0]           v_o [8]
);

  logic [63:0] v_q [8];
  logic [63:0] w_q [16];
  logic [63:0] wt, t1, t2;
  logic        run_q;

  always_comb begin
    if (ctl_i.round < 7'd16) begin
      wt = w_in_i;
    end else begin
      wt = sha512_pkg::sm_s1(w_q[14]) + w_q[9] + sha512_pkg::sm_s0(w_q[1]) + w_q[0];
    end
    t1 = v_q[7] + sha512_pkg::big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + sha512_pkg::Rk[ctl_i.round] + wt;
    t2 = sha512_pkg::big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= ctl_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      for (int i = 0; i < 8; i++) v_q[i] <= cv_i[i];
    end else if (ctl_i.start) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= wt;
    end
  end

  assign v_o = v_q;

`ifndef ASSERT_OFF
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> ctl_i.round < 7'd80) else $error("round out of range");
  a_no_init_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.start && ctl_i.init)) else $error("init during round");
  a_run_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && ctl_i.start) |-> ctl_i.round != 7'd0) else $error("round restarted");
`endif

endmodule

/* rtl/core/sha512_sha384_hash.sv */
// Top level of the SHA-512/SHA-384 streaming hash core.
// One item is accepted per idle cycle; a byte that neither fills the block nor ends the message
// keeps ready high. A byte that fills the 128-byte block starts a compression (one load step,
// 80 rounds in a single shared round unit, one add step), with ready low throughout. An end
// item pads one byte per cycle from the first free byte to the end of the block (0x80, zeros,
// then the 128-bit length in bytes 112..127), i.e. 128 minus the pending bytes, and then
// compresses. With more than 111 bytes pending the block is closed with zeros and
// compressed first, and a second pad pass over a whole block and compression follows. An end item
// whose byte fills the block first compresses that block, then pads a fresh one. The core
// then offers 8 (SHA-512) or 6 (SHA-384) digest words, one per accepted output, before the
// next item is taken. Words come most significant first; last_word marks the final one.
// The block buffer is a 16 x 64-bit memory read by the round sequencer one word per round.
module sha512_sha384_hash (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sha512_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha512_pkg::out_item_t out_data_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StInit = 3'd2;
  localparam logic [2:0] StRun  = 3'd3;
  localparam logic [2:0] StAdd  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]   st_q, st_d;
  logic         dsz_q;
  logic [63:0]  cv_q [8];
  logic [63:0]  mem_q [16];
  logic [6:0]   fill_q;
  logic [127:0] len_q;
  logic         fin_q;
  logic         mark_q;
  logic         two_q;
  logic         last_q;
  logic [6:0]   rnd_q;
  logic [2:0]   oidx_q;
  logic [63:0]  rd_q;
  logic [63:0]  v [8];
  sha512_pkg::rnd_ctl_t ctl;

  logic         acc, byte_full, blk_end, ext;
  logic [3:0]   rd_addr;
  logic [2:0]   last_idx;

  assign acc = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == StIdle);
  assign byte_full = in_data_i.has_byte && (fill_q == 7'd127);
  assign last_idx = dsz_q ? 3'd5 : 3'd7;
  assign rd_addr = (st_q == StInit) ? 4'd0 : rnd_q[3:0] + 4'd1;

  // pad pass writes the last byte of the block
  assign blk_end = (fill_q == 7'd127);
  // current pad pass closes an extra block without the length
  assign ext = two_q || (mark_q && fill_q >= 7'd112);

  assign ctl.init  = (st_q == StInit);
  assign ctl.start = (st_q == StRun);
  assign ctl.round = rnd_q;

  sha512_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .w_in_i (rd_q),
    .cv_i   (cv_q),
    .v_o    (v)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (acc) begin
        if (byte_full) st_d = StInit;
        else if (in_data_i.message_end) st_d = StPad;
      end
      StPad:  if (blk_end) st_d = StInit;
      StInit: st_d = StRun;
      StRun:  if (rnd_q == 7'd79) st_d = StAdd;
      StAdd: begin
        if (last_q) st_d = StOut;
        else if (fin_q) st_d = StPad;
        else st_d = StIdle;
      end
      StOut:  if (out_ready_i && oidx_q == last_idx) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  logic [7:0] pad_byte;
  always_comb begin
    if (mark_q) pad_byte = sha512_pkg::PadByte;
    else if (!two_q && fill_q >= 7'd112) pad_byte = len_q[7'd127 - {fill_q[3:0], 3'd0} -: 8];
    else pad_byte = 8'h00;
  end

  // byte write into the block memory
  logic       wr_en;
  logic [6:0] wr_addr;
  logic [7:0] wr_byte;
  always_comb begin
    wr_en = 1'b0;
    wr_addr = fill_q;
    wr_byte = in_data_i.data_byte;
    if (acc && in_data_i.has_byte) wr_en = 1'b1;
    else if (st_q == StPad) begin
      wr_en = 1'b1;
      wr_byte = pad_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr[6:3]][6'd63 - {wr_addr[2:0], 3'd0} -: 8] <= wr_byte;
    rd_q <= mem_q[rd_addr];
  end

  // one pad state covers: 0x80 marker, zero fill, length bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      dsz_q <= 1'b0;
      for (int i = 0; i < 8; i++) cv_q[i] <= sha512_pkg::Iv512[i];
      fill_q <= '0;
      len_q <= '0;
      fin_q <= 1'b0;
      mark_q <= 1'b0;
      two_q <= 1'b0;
      last_q <= 1'b0;
      rnd_q <= '0;
      oidx_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        dsz_q <= cfg_wdata_i;
        for (int i = 0; i < 8; i++)
          cv_q[i] <= cfg_wdata_i ? sha512_pkg::Iv384[i] : sha512_pkg::Iv512[i];
        fill_q <= '0;
        len_q <= '0;
      end else begin
        case (st_q)
          StIdle: if (acc) begin
            fin_q <= in_data_i.message_end;
            mark_q <= in_data_i.message_end;
            two_q <= 1'b0;
            last_q <= 1'b0;
            if (in_data_i.has_byte) fill_q <= fill_q + 7'd1;
            if (byte_full) begin
              len_q <= len_q + 128'd1024;
            end else if (in_data_i.message_end) begin
              len_q <= len_q + {118'd0, fill_q + {6'd0, in_data_i.has_byte}, 3'd0};
            end
          end
          StPad: begin
            mark_q <= 1'b0;
            if (mark_q && fill_q >= 7'd112) two_q <= 1'b1;
            fill_q <= fill_q + 7'd1;
            if (blk_end) last_q <= !ext;
          end
          StInit: rnd_q <= '0;
          StRun:  rnd_q <= rnd_q + 7'd1;
          StAdd: begin
            for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + v[i];
            fill_q <= '0;
            two_q <= 1'b0;
            oidx_q <= '0;
          end
          StOut: if (out_ready_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == last_idx) begin
              for (int i = 0; i < 8; i++)
                cv_q[i] <= dsz_q ? sha512_pkg::Iv384[i] : sha512_pkg::Iv512[i];
              len_q <= '0;
              fin_q <= 1'b0;
              last_q <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = (st_q == StOut);
  assign out_data_o.digest_word = cv_q[oidx_q];
  assign out_data_o.last_word = (oidx_q == last_idx);

endmodule
